### rtl/core/dsg_pkg.sv
// Shared state codes, request codes, decision type and legality helpers.
package dsg_pkg;

    localparam int STATE_W = 4;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [1:0]         t_req;

    localparam t_state ST_DISCONNECTED   = 4'd0;
    localparam t_state ST_OPENED         = 4'd1;
    localparam t_state ST_IDENTIFIED     = 4'd2;
    localparam t_state ST_IDLE           = 4'd3;
    localparam t_state ST_WARMUP         = 4'd4;
    localparam t_state ST_HOMING         = 4'd5;
    localparam t_state ST_CALIBRATING    = 4'd6;
    localparam t_state ST_SCANNING       = 4'd7;
    localparam t_state ST_CANCELLING     = 4'd8;
    localparam t_state ST_TRANSPORT_LOST = 4'd9;
    localparam t_state ST_FAULTED        = 4'd10;
    localparam t_state ST_ESTOP          = 4'd11;
    localparam t_state NUM_STATES        = 4'd12;

    localparam t_req REQ_MOVE      = 2'd0;
    localparam t_req REQ_TRANSPORT = 2'd1;
    localparam t_req REQ_FAULT     = 2'd2;
    localparam t_req REQ_UNUSED    = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic   status;
        logic   changed;
        t_state next_state;
    } t_decision;

    // Per-source bitmask of ordinary targets (bit t set: move to t allowed).
    function automatic logic [15:0] move_mask(input t_state from);
        logic [15:0] m;
        unique case (from)
            ST_DISCONNECTED:   m = 16'h0002;
            ST_OPENED:         m = 16'h0005;
            ST_IDENTIFIED:     m = 16'h0009;
            ST_IDLE:           m = 16'h00F5;
            ST_WARMUP,
            ST_HOMING,
            ST_CALIBRATING,
            ST_SCANNING:       m = 16'h01F8;
            ST_CANCELLING:     m = 16'h0008;
            ST_TRANSPORT_LOST: m = 16'h0003;
            ST_FAULTED:        m = 16'h000B;
            ST_ESTOP:          m = 16'h0021;
            default:           m = 16'h0000;
        endcase
        return m;
    endfunction

    function automatic logic in_motion_set(input t_state s);
        return (s == ST_IDLE) || (s == ST_HOMING) || (s == ST_CALIBRATING)
            || (s == ST_SCANNING);
    endfunction

    function automatic logic in_busy_set(input t_state s);
        return (s == ST_WARMUP) || (s == ST_HOMING) || (s == ST_CALIBRATING)
            || (s == ST_SCANNING);
    endfunction

    function automatic logic in_recovery_set(input t_state s);
        return (s == ST_TRANSPORT_LOST) || (s == ST_FAULTED) || (s == ST_ESTOP);
    endfunction

endpackage

### rtl/core/dsg_eval.sv
// Legality check and next-state decision for one event.
module dsg_eval (
    input  dsg_pkg::t_state    i_state,
    input  dsg_pkg::t_req      i_req,
    input  dsg_pkg::t_state    i_target,
    output dsg_pkg::t_decision o_dec
);

    logic        legal;
    logic [15:0] mask;

    assign mask = dsg_pkg::move_mask(i_state);

    always_comb begin
        if (i_target >= dsg_pkg::NUM_STATES) begin
            legal = 1'b0;
        end else if (i_target == i_state) begin
            legal = 1'b1;
        end else if (i_target == dsg_pkg::ST_TRANSPORT_LOST ||
                     i_target == dsg_pkg::ST_FAULTED) begin
            legal = 1'b1;
        end else if (i_target == dsg_pkg::ST_ESTOP) begin
            legal = dsg_pkg::in_motion_set(i_state) || i_state == dsg_pkg::ST_WARMUP
                 || i_state == dsg_pkg::ST_CANCELLING;
        end else begin
            legal = mask[i_target];
        end
    end

    always_comb begin
        o_dec.status     = dsg_pkg::STATUS_OK;
        o_dec.next_state = i_state;
        unique case (i_req)
            dsg_pkg::REQ_MOVE: begin
                if (legal) begin
                    o_dec.next_state = i_target;
                end else begin
                    o_dec.status = dsg_pkg::STATUS_REJECTED;
                end
            end
            dsg_pkg::REQ_TRANSPORT: o_dec.next_state = dsg_pkg::ST_TRANSPORT_LOST;
            dsg_pkg::REQ_FAULT:     o_dec.next_state = dsg_pkg::ST_FAULTED;
            dsg_pkg::REQ_UNUSED:    o_dec.status = dsg_pkg::STATUS_REJECTED;
            default:                o_dec.status = dsg_pkg::STATUS_REJECTED;
        endcase
        o_dec.changed = (o_dec.next_state != i_state);
    end

endmodule

### rtl/core/device_state_guard_core.sv
// Device lifecycle guard: input register, one-pass legality decision, result register.
// Each transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the result channel is not stalled; the
// legality table and counter increment resolve in one combinational pass between the
// two registers.
// The input register also absorbs one transaction while a result is stalled downstream.
// Reset (synchronous, active low): state disconnected, counter zero, both stages empty.
module device_state_guard_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_target_state,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [3:0]  o_current_state,
    output logic [31:0] o_transition_count,
    output logic        o_motion_allowed,
    output logic        o_busy_res,
    output logic        o_recovery_required
);

    // Architectural state
    dsg_pkg::t_state        r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    // Input stage: holds one transaction until the result slot can take it
    logic            r_in_valid;
    dsg_pkg::t_req   r_req;
    dsg_pkg::t_state r_target;

    // Result stage
    logic            r_out_valid;
    logic            r_status;
    dsg_pkg::t_state r_out_state;
    logic [31:0]     r_out_count;
    logic            r_motion, r_busy, r_recovery;

    dsg_pkg::t_decision dec;
    logic               advance;
    logic               in_take;
    logic [31:0]        count_view;

    // Decide the event sitting in the input stage against the current state
    dsg_eval u_eval (
        .i_state  (r_state),
        .i_req    (r_req),
        .i_target (r_target),
        .o_dec    (dec)
    );

    // Advance the input stage into the result stage when the result slot
    // is empty or its transaction completes this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    // Commit the decision to architectural state only on advance
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        if (advance) begin
            n_state = dec.next_state;
            if (dec.changed) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end
    end

    // Report the low 32 bits of the counter, zero-extended when narrower
    generate
        if (COUNT_WIDTH >= 32) begin : g_cnt_wide
            assign count_view = n_count[31:0];
        end else begin : g_cnt_narrow
            assign count_view = {{(32-COUNT_WIDTH){1'b0}}, n_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsg_pkg::ST_DISCONNECTED;
            r_count     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            // Hold the input stage unless it drains or refills
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // Drop the result once taken, refill on advance
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req    <= i_req_type;
            r_target <= i_target_state;
        end
        if (advance) begin
            r_status    <= dec.status;
            r_out_state <= dec.next_state;
            r_out_count <= count_view;
            r_motion    <= dsg_pkg::in_motion_set(dec.next_state);
            r_busy      <= dsg_pkg::in_busy_set(dec.next_state);
            r_recovery  <= dsg_pkg::in_recovery_set(dec.next_state);
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_status;
    assign o_current_state     = r_out_state;
    assign o_transition_count  = r_out_count;
    assign o_motion_allowed    = r_motion;
    assign o_busy_res          = r_busy;
    assign o_recovery_required = r_recovery;

    // The counter moves by one exactly when the state really changes
    a_count_tracks_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_state != $past(r_state)) ? (r_count == $past(r_count) + COUNT_WIDTH'(1))
                                               : (r_count == $past(r_count))))
        else $error("counter out of step with state changes");

    // The held state never leaves the twelve defined codes
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state < dsg_pkg::NUM_STATES)
        else $error("state register holds an undefined code");

    // A rejected result reports an unchanged state
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && dec.status == dsg_pkg::STATUS_REJECTED |=> r_state == $past(r_state))
        else $error("rejected event changed the state");

    // Motion and recovery flags exclude each other on every result
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_motion && r_recovery))
        else $error("motion and recovery flags both set");

endmodule
